>>> src/drain_inlet_discharge_rule_defines.svh
// Assertion macros for the drain inlet discharge block.
// Included by the modules that check their own behaviour; needs clk and rst_n in scope.
`ifndef DRAIN_INLET_DISCHARGE_RULE_DEFINES_SVH
`define DRAIN_INLET_DISCHARGE_RULE_DEFINES_SVH

// An antecedent that, once seen, must come with the consequent in the same cycle.
`define DIRL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// A condition that must never be seen outside reset.
`define DIRL_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`endif

>>> src/dirl_pkg.sv
// Shared types, codes and step functions of the drain inlet discharge pipeline.
// No dependencies; every module of the block imports it.
package dirl_pkg;

  typedef enum logic [2:0] {
    RG_WRITE = 3'd0,
    RG_SKIP  = 3'd1,
    RG_BLOCK = 3'd2,
    RG_POND  = 3'd3,
    RG_WEIR  = 3'd4,
    RG_ORIF  = 3'd5,
    RG_ZERO  = 3'd6
  } regime_t;

  localparam logic [2:0] CFG_MODE      = 3'd0;
  localparam logic [2:0] CFG_RULE_CNT  = 3'd1;
  localparam logic [2:0] CFG_TIME_STEP = 3'd2;
  localparam logic [2:0] CFG_CELL_AREA = 3'd3;
  localparam logic [2:0] CFG_SQRT_2G   = 3'd4;
  localparam logic [2:0] CFG_THRESHOLD = 3'd5;
  localparam logic [2:0] CFG_WEIR_COEF = 3'd6;
  localparam logic [2:0] CFG_ORIF_COEF = 3'd7;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_WEIR = 2'd1;
  localparam logic [1:0] KIND_ORIF = 2'd2;

  localparam int SQ_STAGES  = 5;
  localparam int SQ_STEPS   = 4;
  localparam int DIV_QBITS  = 31;
  localparam int DIV_STEPS  = 4;
  localparam int DIV_STAGES = (DIV_QBITS + DIV_STEPS - 1) / DIV_STEPS;

  typedef struct packed {
    logic [1:0]  mode;
    logic [3:0]  rule_count;
    logic [23:0] time_step;
    logic [31:0] cell_area;
    logic [23:0] sqrt_two_g;
    logic [22:0] threshold;
    logic [15:0] weir_coef;
    logic [15:0] orif_coef;
  } cfg_t;

  typedef struct packed {
    logic        vld;
    regime_t     regime;
    logic [23:0] d;
    logic [15:0] coef;
    logic [23:0] wid;
    logic [23:0] parea;
    logic [31:0] pvol;
    logic [39:0] sq_rad;
    logic [21:0] sq_rem;
    logic [19:0] s;
    logic [26:0] p;
    logic [39:0] a;
    logic [50:0] b;
    logic [45:0] pp0;
    logic [44:0] pp1;
    logic [45:0] pp2;
    logic [44:0] pp3;
    logic [31:0] mag;
    logic [55:0] mt;
    logic [55:0] maxv;
    logic        capped;
    logic [55:0] num;
    logic [23:0] rem;
    logic [30:0] q;
    logic        qsat;
  } item_t;

  // One digit of the square root: two radicand bits in, one root bit out.
  function automatic item_t sqrt_step(item_t x);
    item_t       y;
    logic [21:0] tmp;
    logic [21:0] trial;
    y     = x;
    tmp   = {x.sq_rem[19:0], x.sq_rad[39:38]};
    trial = {x.s, 2'b01};
    if (tmp >= trial) begin
      y.sq_rem = tmp - trial;
      y.s      = {x.s[18:0], 1'b1};
    end else begin
      y.sq_rem = tmp;
      y.s      = {x.s[18:0], 1'b0};
    end
    y.sq_rad = {x.sq_rad[37:0], 2'b00};
    return y;
  endfunction

  // One restoring division step producing quotient bit bitpos.
  function automatic item_t div_step(item_t x, logic [23:0] ts, logic [4:0] bitpos);
    item_t       y;
    logic [30:0] nlo;
    logic [24:0] tmp;
    y   = x;
    nlo = x.num[30:0];
    tmp = {x.rem, nlo[bitpos]};
    if (tmp >= {1'b0, ts}) begin
      y.rem       = 24'(tmp - {1'b0, ts});
      y.q[bitpos] = 1'b1;
    end else begin
      y.rem       = tmp[23:0];
      y.q[bitpos] = 1'b0;
    end
    return y;
  endfunction

endpackage

>>> src/dirl_front.sv
// Front stage: rule table, band lookup and regime classification of each word.
// Depends on dirl_pkg.
module dirl_front #(
  parameter int RULE_SLOTS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  dirl_pkg::cfg_t     cfg,
  input  logic               in_action,
  input  logic [2:0]         in_rule_slot,
  input  logic signed [23:0] in_rule_low_depth,
  input  logic signed [23:0] in_rule_high_depth,
  input  logic [1:0]         in_rule_kind,
  input  logic [15:0]        in_rule_factor,
  input  logic signed [23:0] in_flood_depth,
  input  logic [31:0]        in_overflow_volume,
  input  logic [23:0]        in_weir_width,
  input  logic [23:0]        in_orifice_area,
  input  logic [23:0]        in_ponded_area,
  input  logic               in_cell_valid,
  output dirl_pkg::item_t    item_o
);
  import dirl_pkg::*;

  logic signed [23:0] band_low_r    [RULE_SLOTS];
  logic signed [23:0] band_high_r   [RULE_SLOTS];
  logic [1:0]         band_kind_r   [RULE_SLOTS];
  logic [15:0]        band_factor_r [RULE_SLOTS];

  item_t       item_r;
  item_t       item_nxt;
  logic        hit;
  logic [1:0]  hk;
  logic [15:0] hf;
  logic [1:0]  kind;
  logic [15:0] coef;

  always_ff @(posedge clk) begin
    if (en && in_valid && in_action) begin
      for (int i = 0; i < RULE_SLOTS; i++) begin
        if (int'(in_rule_slot) == i) begin
          band_low_r[i]    <= in_rule_low_depth;
          band_high_r[i]   <= in_rule_high_depth;
          band_kind_r[i]   <= in_rule_kind;
          band_factor_r[i] <= in_rule_factor;
        end
      end
    end
  end

  // Walking down from the top leaves the lowest matching entry in place.
  always_comb begin
    hit = 1'b0;
    hk  = KIND_NONE;
    hf  = '0;
    for (int i = RULE_SLOTS - 1; i >= 0; i--) begin
      if (cfg.mode[1] && (i < int'(cfg.rule_count)) &&
          (in_flood_depth >= band_low_r[i]) && (in_flood_depth < band_high_r[i])) begin
        hit = 1'b1;
        hk  = band_kind_r[i];
        hf  = band_factor_r[i];
      end
    end
  end

  always_comb begin
    if (hit) begin
      kind = (hk == KIND_WEIR || hk == KIND_ORIF) ? hk : KIND_NONE;
      coef = hf;
    end else if (in_flood_depth[22:0] == 23'd0) begin
      kind = KIND_NONE;
      coef = '0;
    end else if (in_flood_depth[22:0] <= cfg.threshold) begin
      kind = KIND_WEIR;
      coef = cfg.weir_coef;
    end else begin
      kind = KIND_ORIF;
      coef = cfg.orif_coef;
    end
  end

  always_comb begin
    item_nxt        = '0;
    item_nxt.vld    = in_valid;
    item_nxt.pvol   = in_overflow_volume;
    item_nxt.parea  = in_ponded_area;
    item_nxt.coef   = coef;
    item_nxt.wid    = (kind == KIND_WEIR) ? in_weir_width : in_orifice_area;
    item_nxt.d      = $unsigned(in_flood_depth);
    if (in_action) begin
      item_nxt.regime = RG_WRITE;
      item_nxt.pvol   = '0;
    end else if (!in_cell_valid) begin
      item_nxt.regime = RG_SKIP;
    end else if (!cfg.mode[0] && (in_overflow_volume != 32'd0)) begin
      item_nxt.regime = RG_BLOCK;
    end else if (in_flood_depth < 0) begin
      item_nxt.regime = RG_POND;
      item_nxt.d      = $unsigned(-in_flood_depth);
    end else if (kind == KIND_WEIR) begin
      item_nxt.regime = RG_WEIR;
    end else if (kind == KIND_ORIF) begin
      item_nxt.regime = RG_ORIF;
    end else begin
      item_nxt.regime = RG_ZERO;
    end
    item_nxt.sq_rad = {item_nxt.d, 16'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_r.vld <= 1'b0;
    end else if (en) begin
      item_r <= item_nxt;
    end
  end

  assign item_o = item_r;

endmodule

>>> src/dirl_sqrt.sv
// Pipelined digit-by-digit square root of the depth, four root bits per stage.
// Depends on dirl_pkg.
module dirl_sqrt (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  dirl_pkg::item_t item_i,
  output dirl_pkg::item_t item_o
);
  import dirl_pkg::*;

  item_t st_in  [SQ_STAGES];
  item_t st_nxt [SQ_STAGES];
  item_t st_r   [SQ_STAGES];

  assign st_in[0] = item_i;

  for (genvar g = 0; g < SQ_STAGES; g++) begin : g_stage
    if (g > 0) begin : g_link
      assign st_in[g] = st_r[g-1];
    end

    always_comb begin
      st_nxt[g] = st_in[g];
      for (int j = 0; j < SQ_STEPS; j++) begin
        st_nxt[g] = sqrt_step(st_nxt[g]);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_r[g].vld <= 1'b0;
      end else if (en) begin
        st_r[g] <= st_nxt[g];
      end
    end
  end

  assign item_o = st_r[SQ_STAGES-1];

endmodule

>>> src/dirl_mag.sv
// Discharge magnitude: d^1.5, coefficient products, split wide product,
// saturation and the cell-water cap test. Depends on dirl_pkg.
module dirl_mag (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  dirl_pkg::cfg_t  cfg,
  input  dirl_pkg::item_t item_i,
  output dirl_pkg::item_t item_o
);
  import dirl_pkg::*;

  item_t m1_r, m1_nxt, m2_r, m2_nxt, m3_r, m3_nxt;
  item_t m4_r, m4_nxt, m5_r, m5_nxt, m6_r, m6_nxt;

  logic [43:0] dsp;
  logic [47:0] pv;
  logic [90:0] sum;
  logic [46:0] hi;

  always_comb begin
    m1_nxt  = item_i;
    dsp     = item_i.d * item_i.s;
    pv      = item_i.d * item_i.parea;
    m1_nxt.p = dsp[42:16];
    m1_nxt.a = item_i.coef * item_i.wid;
    if (item_i.regime == RG_POND) begin
      m1_nxt.pvol = pv[47:16];
    end
  end

  always_comb begin
    m2_nxt   = m1_r;
    m2_nxt.b = cfg.sqrt_two_g * ((m1_r.regime == RG_WEIR) ? m1_r.p : {7'b0, m1_r.s});
  end

  // The wide product is cut into four partial products of at most 20 by 26 bits.
  always_comb begin
    m3_nxt     = m2_r;
    m3_nxt.pp0 = m2_r.a[19:0]  * m2_r.b[25:0];
    m3_nxt.pp1 = m2_r.a[19:0]  * m2_r.b[50:26];
    m3_nxt.pp2 = m2_r.a[39:20] * m2_r.b[25:0];
    m3_nxt.pp3 = m2_r.a[39:20] * m2_r.b[50:26];
  end

  always_comb begin
    m4_nxt = m3_r;
    sum    = 91'(m3_r.pp0) + (91'(m3_r.pp1) << 26) + (91'(m3_r.pp2) << 20) +
             (91'(m3_r.pp3) << 46);
    hi     = sum[90:44];
    m4_nxt.mag = (hi > 47'h0000_8000_0000) ? 32'h8000_0000 : hi[31:0];
  end

  always_comb begin
    m5_nxt      = m4_r;
    m5_nxt.mt   = m4_r.mag * cfg.time_step;
    m5_nxt.maxv = m4_r.d * cfg.cell_area;
  end

  // Capped words divide the cell water by the step; ponded words divide volume.
  always_comb begin
    m6_nxt        = m5_r;
    m6_nxt.capped = ((m5_r.regime == RG_WEIR) || (m5_r.regime == RG_ORIF)) &&
                    (cfg.time_step != 24'd0) && (m5_r.mt > m5_r.maxv);
    m6_nxt.num    = m6_nxt.capped ? m5_r.maxv : {8'b0, m5_r.pvol, 16'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_r.vld <= 1'b0;
      m2_r.vld <= 1'b0;
      m3_r.vld <= 1'b0;
      m4_r.vld <= 1'b0;
      m5_r.vld <= 1'b0;
      m6_r.vld <= 1'b0;
    end else if (en) begin
      m1_r <= m1_nxt;
      m2_r <= m2_nxt;
      m3_r <= m3_nxt;
      m4_r <= m4_nxt;
      m5_r <= m5_nxt;
      m6_r <= m6_nxt;
    end
  end

  assign item_o = m6_r;

endmodule

>>> src/dirl_div.sv
// Pipelined restoring divider by the time step, up to four quotient bits per stage,
// with an up-front overflow test. Depends on dirl_pkg.
module dirl_div (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  dirl_pkg::cfg_t  cfg,
  input  dirl_pkg::item_t item_i,
  output dirl_pkg::item_t item_o
);
  import dirl_pkg::*;

  item_t st_in  [DIV_STAGES];
  item_t st_nxt [DIV_STAGES];
  item_t st_r   [DIV_STAGES];

  assign st_in[0] = item_i;

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
    if (g > 0) begin : g_link
      assign st_in[g] = st_r[g-1];
    end

    always_comb begin
      st_nxt[g] = st_in[g];
      if (g == 0) begin
        // A quotient of 2^31 or more shows as the top bits reaching the divisor.
        st_nxt[g].qsat = (st_in[g].num[55:31] >= {1'b0, cfg.time_step});
        st_nxt[g].rem  = st_in[g].num[54:31];
      end
      for (int j = 0; j < DIV_STEPS; j++) begin
        if (g * DIV_STEPS + j < DIV_QBITS) begin
          st_nxt[g] = div_step(st_nxt[g], cfg.time_step,
                               5'(DIV_QBITS - 1 - (g * DIV_STEPS + j)));
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_r[g].vld <= 1'b0;
      end else if (en) begin
        st_r[g] <= st_nxt[g];
      end
    end
  end

  assign item_o = st_r[DIV_STAGES-1];

endmodule

>>> src/drain_inlet_discharge_rule.sv
// Drain inlet discharge pipeline: one word in and one result out per cycle
// while no valid result is stalled at the output. From acceptance to out_valid
// a word passes the front, square-root, magnitude, divider and output registers.
// Stalling a valid output freezes every stage; in_stall is out_stall gated by out_valid.
// Reset clears all valid bits and loads the register defaults; the rule table
// holds no reset value and must be written before it is used.
`include "drain_inlet_discharge_rule_defines.svh"

module drain_inlet_discharge_rule #(
  parameter int RULE_SLOTS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wen,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_action,
  input  logic [2:0]         in_rule_slot,
  input  logic signed [23:0] in_rule_low_depth,
  input  logic signed [23:0] in_rule_high_depth,
  input  logic [1:0]         in_rule_kind,
  input  logic [15:0]        in_rule_factor,
  input  logic signed [23:0] in_flood_depth,
  input  logic [31:0]        in_overflow_volume,
  input  logic [23:0]        in_weir_width,
  input  logic [23:0]        in_orifice_area,
  input  logic [23:0]        in_ponded_area,
  input  logic               in_cell_valid,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_new_flow,
  output logic [2:0]         out_flow_regime,
  output logic               out_flow_capped,
  output logic [31:0]        out_ponded_volume
);
  import dirl_pkg::*;

  cfg_t  cfg_r;
  item_t front_item, sqrt_item, mag_item, div_item;
  logic  en;

  logic        out_valid_r;
  logic [31:0] out_new_flow_r, out_new_flow_nxt;
  logic [2:0]  out_flow_regime_r;
  logic        out_flow_capped_r, out_flow_capped_nxt;
  logic [31:0] out_ponded_volume_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode       <= 2'd0;
      cfg_r.rule_count <= 4'd0;
      cfg_r.time_step  <= 24'd65536;
      cfg_r.cell_area  <= 32'd65536;
      cfg_r.sqrt_two_g <= 24'd290283;
      cfg_r.threshold  <= 23'd65536;
      cfg_r.weir_coef  <= 16'd4096;
      cfg_r.orif_coef  <= 16'd4096;
    end else if (cfg_wen) begin
      case (cfg_index)
        CFG_MODE:      cfg_r.mode       <= cfg_wdata[1:0];
        CFG_RULE_CNT:  cfg_r.rule_count <= cfg_wdata[3:0];
        CFG_TIME_STEP: cfg_r.time_step  <= cfg_wdata[23:0];
        CFG_CELL_AREA: cfg_r.cell_area  <= cfg_wdata;
        CFG_SQRT_2G:   cfg_r.sqrt_two_g <= cfg_wdata[23:0];
        CFG_THRESHOLD: cfg_r.threshold  <= cfg_wdata[22:0];
        CFG_WEIR_COEF: cfg_r.weir_coef  <= cfg_wdata[15:0];
        CFG_ORIF_COEF: cfg_r.orif_coef  <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  dirl_front #(.RULE_SLOTS(RULE_SLOTS)) u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .en                 (en),
    .in_valid           (in_valid),
    .cfg                (cfg_r),
    .in_action          (in_action),
    .in_rule_slot       (in_rule_slot),
    .in_rule_low_depth  (in_rule_low_depth),
    .in_rule_high_depth (in_rule_high_depth),
    .in_rule_kind       (in_rule_kind),
    .in_rule_factor     (in_rule_factor),
    .in_flood_depth     (in_flood_depth),
    .in_overflow_volume (in_overflow_volume),
    .in_weir_width      (in_weir_width),
    .in_orifice_area    (in_orifice_area),
    .in_ponded_area     (in_ponded_area),
    .in_cell_valid      (in_cell_valid),
    .item_o             (front_item)
  );

  dirl_sqrt u_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .item_i (front_item),
    .item_o (sqrt_item)
  );

  dirl_mag u_mag (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .cfg    (cfg_r),
    .item_i (sqrt_item),
    .item_o (mag_item)
  );

  dirl_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .cfg    (cfg_r),
    .item_i (mag_item),
    .item_o (div_item)
  );

  always_comb begin
    out_new_flow_nxt    = '0;
    out_flow_capped_nxt = 1'b0;
    case (div_item.regime)
      RG_POND: begin
        if (div_item.pvol == 32'd0) begin
          out_new_flow_nxt = '0;
        end else if (div_item.qsat) begin
          out_new_flow_nxt = 32'h7FFF_FFFF;
        end else begin
          out_new_flow_nxt = {1'b0, div_item.q};
        end
      end
      RG_WEIR, RG_ORIF: begin
        out_flow_capped_nxt = div_item.capped;
        out_new_flow_nxt    = div_item.capped ? (32'd0 - {1'b0, div_item.q}) :
                                                (32'd0 - div_item.mag);
      end
      default: out_new_flow_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= div_item.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_new_flow_r      <= out_new_flow_nxt;
      out_flow_regime_r   <= div_item.regime;
      out_flow_capped_r   <= out_flow_capped_nxt;
      out_ponded_volume_r <= div_item.pvol;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_new_flow      = $signed(out_new_flow_r);
  assign out_flow_regime   = out_flow_regime_r;
  assign out_flow_capped   = out_flow_capped_r;
  assign out_ponded_volume = out_ponded_volume_r;

  `DIRL_ASSERT_IMP(a_write_quiet, out_valid && (out_flow_regime == RG_WRITE), (out_new_flow == 0) && (out_ponded_volume == 0) && !out_flow_capped)
  `DIRL_ASSERT_NEVER(a_cap_regime, out_valid && out_flow_capped && (out_flow_regime != RG_WEIR) && (out_flow_regime != RG_ORIF))
  `DIRL_ASSERT_IMP(a_drain_sign, out_valid && ((out_flow_regime == RG_WEIR) || (out_flow_regime == RG_ORIF)), out_new_flow[31] || (out_new_flow == 0))
  `DIRL_ASSERT_IMP(a_pond_sign, out_valid && (out_flow_regime == RG_POND), !out_new_flow[31])

endmodule

>>> bench/dirl_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the drain inlet discharge block: predicts each result from accepted words.
// Depends on dirl_pkg for the regime codes, register indexes and rule kinds.
module dirl_checker
  import dirl_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wen,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               in_action,
  input  logic [2:0]         in_rule_slot,
  input  logic signed [23:0] in_rule_low_depth,
  input  logic signed [23:0] in_rule_high_depth,
  input  logic [1:0]         in_rule_kind,
  input  logic [15:0]        in_rule_factor,
  input  logic signed [23:0] in_flood_depth,
  input  logic [31:0]        in_overflow_volume,
  input  logic [23:0]        in_weir_width,
  input  logic [23:0]        in_orifice_area,
  input  logic [23:0]        in_ponded_area,
  input  logic               in_cell_valid,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] out_new_flow,
  input  logic [2:0]         out_flow_regime,
  input  logic               out_flow_capped,
  input  logic [31:0]        out_ponded_volume,
  output int                 fail_count,
  output int                 awaited
);

  typedef struct {
    logic [31:0] flow;
    regime_t     regime;
    logic        capped;
    logic [31:0] pvol;
  } discharge_t;

  localparam int SLOTS = 8;
  localparam logic [63:0] MAG_LIMIT = 64'h8000_0000;
  localparam logic [63:0] POND_LIMIT = 64'h7FFF_FFFF;

  discharge_t        discharge_q[$];
  logic [1:0]        mode;
  logic [3:0]        rule_cnt;
  logic [23:0]       tstep;
  logic [31:0]       area;
  logic [23:0]       root2g;
  logic [22:0]       thresh;
  logic [15:0]       weir_c;
  logic [15:0]       orif_c;
  logic signed [23:0] band_lo[SLOTS];
  logic signed [23:0] band_hi[SLOTS];
  logic [1:0]        band_kd[SLOTS];
  logic [15:0]       band_fc[SLOTS];

  assign awaited = discharge_q.size();

  function automatic logic [63:0] floor_root(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // Works out the result of the accepted word and applies any rule table write.
  function automatic discharge_t predict_discharge();
    discharge_t         r;
    logic signed [23:0] dep;
    logic [63:0]        d, vol, q, s, p, mag, maxv, coef, wid;
    logic [127:0]       prod;
    logic [1:0]         kind;
    bit                 chosen;
    int                 n;
    dep = in_flood_depth;
    r.flow = 0;
    r.capped = 0;
    r.pvol = in_overflow_volume;
    if (in_action) begin
      band_lo[in_rule_slot] = in_rule_low_depth;
      band_hi[in_rule_slot] = in_rule_high_depth;
      band_kd[in_rule_slot] = in_rule_kind;
      band_fc[in_rule_slot] = in_rule_factor;
      r.regime = RG_WRITE;
      r.pvol = 0;
    end else if (!in_cell_valid) begin
      r.regime = RG_SKIP;
    end else if (!mode[0] && in_overflow_volume != 0) begin
      r.regime = RG_BLOCK;
    end else if (dep < 0) begin
      d = 64'(-longint'(dep));
      vol = (d * 64'(in_ponded_area)) >> 16;
      if (tstep == 0) q = (vol == 0) ? 64'd0 : POND_LIMIT;
      else q = (vol << 16) / 64'(tstep);
      if (q > POND_LIMIT) q = POND_LIMIT;
      r.flow = q[31:0];
      r.pvol = vol[31:0];
      r.regime = RG_POND;
    end else begin
      d = 64'(dep);
      kind = KIND_NONE;
      coef = 0;
      chosen = 0;
      if (mode[1]) begin
        n = (rule_cnt < SLOTS) ? int'(rule_cnt) : SLOTS;
        for (int i = 0; i < n; i++) begin
          if (!chosen && dep >= band_lo[i] && dep < band_hi[i]) begin
            kind = (band_kd[i] == KIND_WEIR || band_kd[i] == KIND_ORIF) ? band_kd[i]
                                                                         : KIND_NONE;
            coef = 64'(band_fc[i]);
            chosen = 1;
          end
        end
      end
      if (!chosen) begin
        if (d > 0 && d <= 64'(thresh)) begin
          kind = KIND_WEIR;
          coef = 64'(weir_c);
        end else if (d > 64'(thresh)) begin
          kind = KIND_ORIF;
          coef = 64'(orif_c);
        end
      end
      if (kind == KIND_NONE) begin
        r.regime = RG_ZERO;
      end else begin
        s = floor_root(d << 16);
        if (kind == KIND_WEIR) begin
          p = (d * s) >> 16;
          wid = 64'(in_weir_width);
          prod = 128'(coef * wid) * 128'(64'(root2g) * p);
          r.regime = RG_WEIR;
        end else begin
          wid = 64'(in_orifice_area);
          prod = 128'(coef * wid) * 128'(64'(root2g) * s);
          r.regime = RG_ORIF;
        end
        prod = prod >> 44;
        mag = (prod > 128'(MAG_LIMIT)) ? MAG_LIMIT : prod[63:0];
        maxv = d * 64'(area);
        if (tstep != 0 && mag * 64'(tstep) > maxv) begin
          mag = maxv / 64'(tstep);
          if (mag > MAG_LIMIT) mag = MAG_LIMIT;
          r.capped = 1;
        end
        r.flow = 32'(64'd0 - mag);
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    discharge_t e;
    int         errs;
    errs = 0;
    if (!rst_n) begin
      mode <= 0;
      rule_cnt <= 0;
      tstep <= 24'd65536;
      area <= 32'd65536;
      root2g <= 24'd290283;
      thresh <= 23'd65536;
      weir_c <= 16'd4096;
      orif_c <= 16'd4096;
      fail_count <= 0;
      discharge_q.delete();
    end else begin
      if (cfg_wen) begin
        case (cfg_index)
          CFG_MODE:      mode <= cfg_wdata[1:0];
          CFG_RULE_CNT:  rule_cnt <= cfg_wdata[3:0];
          CFG_TIME_STEP: tstep <= cfg_wdata[23:0];
          CFG_CELL_AREA: area <= cfg_wdata;
          CFG_SQRT_2G:   root2g <= cfg_wdata[23:0];
          CFG_THRESHOLD: thresh <= cfg_wdata[22:0];
          CFG_WEIR_COEF: weir_c <= cfg_wdata[15:0];
          CFG_ORIF_COEF: orif_c <= cfg_wdata[15:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) discharge_q.push_back(predict_discharge());
      if (out_valid && !out_stall) begin
        if (discharge_q.size() == 0) begin
          $error("result word with nothing expected");
          errs++;
        end else begin
          e = discharge_q.pop_front();
          if (out_new_flow !== e.flow) begin
            $error("new_flow expected %h got %h", e.flow, out_new_flow);
            errs++;
          end
          if (out_flow_regime !== e.regime) begin
            $error("flow_regime expected %0d got %0d", e.regime, out_flow_regime);
            errs++;
          end
          if (out_flow_capped !== e.capped) begin
            $error("flow_capped expected %0d got %0d", e.capped, out_flow_capped);
            errs++;
          end
          if (out_ponded_volume !== e.pvol) begin
            $error("ponded_volume expected %h got %h", e.pvol, out_ponded_volume);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
  end

endmodule

>>> bench/drain_inlet_discharge_rule_tb.sv
`timescale 1ns / 1ps
// Top of the drain inlet discharge bench: clock, reset, register phases and stimulus.
// Depends on dirl_pkg, the block under test and the dirl_checker scoreboard.
module drain_inlet_discharge_rule_tb;
  import dirl_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int PHASES = 12;
  localparam int PHASE_WORDS = 170;
  localparam int SETTLE = 30;

  logic               clk;
  logic               rst_n;
  logic               cfg_wen;
  logic [2:0]         cfg_index;
  logic [31:0]        cfg_wdata;
  logic               in_valid;
  logic               in_stall;
  logic               in_action;
  logic [2:0]         in_rule_slot;
  logic signed [23:0] in_rule_low_depth;
  logic signed [23:0] in_rule_high_depth;
  logic [1:0]         in_rule_kind;
  logic [15:0]        in_rule_factor;
  logic signed [23:0] in_flood_depth;
  logic [31:0]        in_overflow_volume;
  logic [23:0]        in_weir_width;
  logic [23:0]        in_orifice_area;
  logic [23:0]        in_ponded_area;
  logic               in_cell_valid;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] out_new_flow;
  logic [2:0]         out_flow_regime;
  logic               out_flow_capped;
  logic [31:0]        out_ponded_volume;
  int                 fail_count;
  int                 awaited;
  int                 cycles;
  bit                 no_gaps;
  bit                 long_hold;

  drain_inlet_discharge_rule u_top (.*);

  dirl_checker u_chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("drain_inlet_discharge_rule_tb NOT OK");
        $finish;
      end
    end
  end

  // Receiver: a random hold-off before each result word unless no_gaps is set, or one long stretch on request.
  initial begin
    int n;
    out_stall = 1;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      n = no_gaps ? 0 : $urandom_range(0, 11);
      if (long_hold) begin
        n = 400;
        long_hold = 0;
      end
      if (n > 0) begin
        out_stall <= 1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_wen <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
  endtask

  task automatic send_word();
    int n;
    n = no_gaps ? 0 : $urandom_range(0, 11);
    if (n > 0) begin
      in_valid <= 0;
      repeat (n) @(negedge clk);
    end
    in_valid <= 1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic set_rule(logic [2:0] slot, logic signed [23:0] lo, logic signed [23:0] hi,
                          logic [1:0] kind, logic [15:0] fac);
    in_action <= 1;
    in_rule_slot <= slot;
    in_rule_low_depth <= lo;
    in_rule_high_depth <= hi;
    in_rule_kind <= kind;
    in_rule_factor <= fac;
    in_flood_depth <= 24'($urandom);
    in_overflow_volume <= $urandom;
    in_cell_valid <= 1'($urandom);
    send_word();
  endtask

  task automatic set_point(logic signed [23:0] dep, logic [31:0] ovf, logic [23:0] wid,
                           logic [23:0] oa, logic [23:0] pa, logic cv);
    in_action <= 0;
    in_rule_slot <= 3'($urandom);
    in_rule_low_depth <= 24'($urandom);
    in_rule_high_depth <= 24'($urandom);
    in_rule_kind <= 2'($urandom);
    in_rule_factor <= 16'($urandom);
    in_flood_depth <= dep;
    in_overflow_volume <= ovf;
    in_weir_width <= wid;
    in_orifice_area <= oa;
    in_ponded_area <= pa;
    in_cell_valid <= cv;
    send_word();
  endtask

  function automatic logic signed [23:0] pick_depth();
    case ($urandom_range(0, 5))
      0: return 24'(32'($urandom_range(0, 131072)));
      1: return -24'(32'($urandom_range(1, 131072)));
      2: return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
      3: return 24'd0;
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [23:0] pick24();
    case ($urandom_range(0, 3))
      0: return 24'(32'($urandom_range(0, 131072)));
      1: return $urandom_range(0, 1) ? 24'hFFFFFF : 24'h0;
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic random_word();
    logic signed [23:0] a, b;
    if ($urandom_range(0, 9) == 0) begin
      a = pick_depth();
      b = pick_depth();
      if ($urandom_range(0, 3) != 0 && a > b)
        set_rule(3'($urandom), b, a, 2'($urandom), 16'($urandom));
      else
        set_rule(3'($urandom), a, b, 2'($urandom), 16'($urandom));
    end else begin
      set_point(pick_depth(), ($urandom_range(0, 2) == 0) ? $urandom : 32'd0,
                pick24(), pick24(), pick24(), $urandom_range(0, 15) != 0);
    end
  endtask

  task automatic settle();
    in_valid <= 0;
    while (awaited != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic load_regs(int ph);
    logic [31:0] v[8];
    if (ph == 1) begin
      v = '{32'd1, 32'd8, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0};
    end else if (ph == 2) begin
      v = '{32'd3, 32'd8, 32'hFFFFFF, 32'hFFFFFFFF, 32'hFFFFFF, 32'h7FFFFF, 32'hFFFF,
            32'hFFFF};
    end else if (ph == 3) begin
      v = '{32'd2, 32'd0, 32'd1, 32'd0, 32'd1, 32'd0, 32'd1, 32'd1};
    end else begin
      v[0] = $urandom_range(0, 3);
      v[1] = $urandom_range(0, 8);
      v[2] = $urandom_range(0, 1) ? 32'($urandom_range(1, 262144)) : 32'($urandom_range(1, 24'hFFFFFF));
      v[3] = $urandom_range(0, 1) ? 32'($urandom_range(0, 1 << 22)) : $urandom;
      v[4] = $urandom_range(0, 1) ? 32'd290283 : 32'($urandom_range(0, 24'hFFFFFF));
      v[5] = $urandom_range(0, 1) ? 32'($urandom_range(0, 131072)) : 32'($urandom_range(0, 23'h7FFFFF));
      v[6] = $urandom_range(0, 65535);
      v[7] = $urandom_range(0, 65535);
    end
    for (int i = 0; i < 8; i++) write_reg(3'(i), v[i]);
    cfg_wen <= 0;
  endtask

  initial begin
    rst_n = 0;
    cfg_wen = 0;
    cfg_index = 0;
    cfg_wdata = 0;
    in_valid = 0;
    in_action = 0;
    in_rule_slot = 0;
    in_rule_low_depth = 0;
    in_rule_high_depth = 0;
    in_rule_kind = 0;
    in_rule_factor = 0;
    in_flood_depth = 0;
    in_overflow_volume = 0;
    in_weir_width = 0;
    in_orifice_area = 0;
    in_ponded_area = 0;
    in_cell_valid = 0;
    no_gaps = 0;
    long_hold = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // Every table slot is written first, so that no band is ever read before it is set.
    set_rule(0, 24'h800000, 24'h000000, KIND_NONE, 16'h0000);
    set_rule(1, 24'h000000, 24'h008000, KIND_WEIR, 16'hFFFF);
    set_rule(2, 24'h008000, 24'h020000, KIND_ORIF, 16'h1000);
    set_rule(3, 24'h020000, 24'h7FFFFF, 2'd3, 16'h0800);
    set_rule(4, 24'h010000, 24'h010000, KIND_WEIR, 16'h2000);
    set_rule(5, 24'h7FFFFF, 24'h800000, KIND_ORIF, 16'h3000);
    set_rule(6, 24'h000100, 24'h7FFFFF, KIND_ORIF, 16'hFFFF);
    set_rule(7, 24'h800000, 24'h7FFFFF, KIND_WEIR, 16'h1000);
    set_point(24'h010000, 32'd5, 24'h010000, 24'h010000, 24'h010000, 0);
    set_point(24'h010000, 32'hFFFFFFFF, 24'h010000, 24'h010000, 24'h010000, 1);
    set_point(24'h000000, 32'd0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1);
    set_point(24'h800000, 32'd0, 24'h0, 24'h0, 24'hFFFFFF, 1);
    set_point(24'hFFFFFF, 32'd0, 24'h0, 24'h0, 24'h000000, 1);
    set_point(24'h7FFFFF, 32'd0, 24'hFFFFFF, 24'hFFFFFF, 24'h0, 1);
    set_point(24'h010000, 32'd0, 24'hFFFFFF, 24'hFFFFFF, 24'h0, 1);
    set_point(24'h010001, 32'd0, 24'hFFFFFF, 24'hFFFFFF, 24'h0, 1);
    set_point(24'h000001, 32'd0, 24'h010000, 24'h010000, 24'h0, 1);
    set_point(24'h100000, 32'd0, 24'h000000, 24'h000000, 24'h0, 1);
    settle();

    for (int ph = 1; ph <= PHASES; ph++) begin
      load_regs(ph);
      no_gaps = (ph % 4 == 0);
      if (ph == 5) long_hold = 1;
      if (ph == 2) begin
        // Table bands tried one by one with the table switched on.
        set_point(24'h004000, 32'd0, 24'h010000, 24'h010000, 24'h0, 1);
        set_point(24'h018000, 32'd0, 24'h010000, 24'h010000, 24'h0, 1);
        set_point(24'h030000, 32'd0, 24'h010000, 24'h010000, 24'h0, 1);
        set_point(24'h000000, 32'd0, 24'h010000, 24'h010000, 24'h0, 1);
      end
      for (int i = 0; i < PHASE_WORDS; i++) random_word();
      settle();
    end

    if (fail_count == 0) $display("drain_inlet_discharge_rule_tb OK");
    else $display("drain_inlet_discharge_rule_tb NOT OK");
    $finish;
  end

endmodule
